// ===== design/capsule_closest_point_top_macros.svh =====
// assertion macros shared by the capsule closest point checker
// expects clk and rst_n in the scope where a macro is used
`ifndef CAPSULE_CLOSEST_POINT_TOP_MACROS_SVH
`define CAPSULE_CLOSEST_POINT_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define CCP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("capsule closest point check failed");

// next-cycle implication, off during reset
`define CCP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("capsule closest point check failed");

// checked at every edge, reset included
`define CCP_ASSERT_ALL(lbl, cond) \
    lbl: assert property (@(posedge clk) (cond)) \
        else $error("capsule closest point check failed");

`endif

// ===== design/ccp_pkg.sv =====
// shared constants, types and saturation helper for the capsule closest point block
// no dependencies
package ccp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QW        = 32;                   // fixed point word
    localparam int PW        = 2 * QW - FRAC_BITS;   // shifted product
    localparam int OW        = 2 * QW + 1 - FRAC_BITS; // h times axis, shifted
    localparam int NW        = PW + 2;               // projection sums
    localparam int RW        = NW + 1;               // span divider remainder
    localparam int SW        = PW + 3;               // saturation input
    localparam int TW        = 32;                   // span fraction bits
    localparam int DIV_STEPS = TW;
    localparam int SQ_STEPS  = 32;
    localparam int PD_STEPS  = QW;
    localparam int CIW       = 3;

    localparam logic [63:0] ONE_HI = 64'(1) << (FRAC_BITS + QW);

    typedef enum logic [CIW-1:0] {
        CFG_BASE_I_XY  = 3'd0,
        CFG_BASE_IZ_JX = 3'd1,
        CFG_BASE_J_YZ  = 3'd2,
        CFG_BASE_K_XY  = 3'd3,
        CFG_BASE_KZ_CX = 3'd4,
        CFG_BASE_C_YZ  = 3'd5,
        CFG_RAD_HALF   = 3'd6
    } cfg_idx_t;

    // index 0 is x
    typedef logic [2:0][QW-1:0] vec_t;

    typedef struct packed {
        vec_t           ri;
        vec_t           rj;
        vec_t           rk;
        vec_t           rc;
        logic [QW-1:0]  r;
        logic [QW-1:0]  h;
    } cfg_t;

    typedef struct packed {
        vec_t                  pt;
        vec_t                  top;
        vec_t                  bot;
        vec_t                  hv;
        logic signed [NW-1:0]  n;
        logic signed [NW-1:0]  d;
    } proj_t;

    function automatic logic [QW-1:0] sat32(input logic signed [SW-1:0] v);
        logic [SW-QW:0] hi;
        hi = v[SW-1:QW-1];
        if (hi == '0 || hi == '1)
            sat32 = v[QW-1:0];
        else if (v[SW-1])
            sat32 = {1'b1, {(QW-1){1'b0}}};
        else
            sat32 = {1'b0, {(QW-1){1'b1}}};
    endfunction

endpackage

// ===== design/capsule_closest_point_top.sv =====
// capsule closest point: an input transaction passes through to result valid via
// 7 front stages, 32 span divider stages, 2 axis point stages, 3 distance stages,
// 32 square root stages, 32 push divider stages and 1 output stage
// throughput one transaction per cycle; the whole pipeline holds while the result stalls
// reset clears all valid bits and loads the identity base transform, r = 0, h = 0
// depends on ccp_pkg, ccp_front, ccp_sphere
module capsule_closest_point_top
    import ccp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    // input stream
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // point_x, point_y, point_z, frame_up_x, frame_up_y, frame_up_z,
    // frame_pos_x, frame_pos_y, frame_pos_z (32 bits each, from bit 0 up)
    input  logic [287:0]    s_axis_tdata,
    // result stream
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // near_x, near_y, near_z (32 bits each, from bit 0 up)
    output logic [95:0]     m_axis_tdata,
    // configuration write channel
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [CIW-1:0]  cfg_index,
    input  logic [63:0]     cfg_data
);

    // span divider stage payload
    typedef struct packed {
        vec_t           pt;
        vec_t           top;
        vec_t           bot;
        vec_t           hv;
        logic [RW-1:0]  rem;
        logic [RW-1:0]  den;
        logic [TW-1:0]  t;
        logic           in_span;
        logic           use_top;
    } div_t;

    // configuration registers
    logic [63:0] base_i_xy_reg, base_iz_jx_reg, base_j_yz_reg, base_k_xy_reg;
    logic [63:0] base_kz_cx_reg, base_c_yz_reg, rad_half_reg;
    logic [63:0] rsq_reg, rsq_next;
    cfg_t        cfg_w;

    // the whole pipeline advances together; the last sphere stage is the output register
    logic        en;
    vec_t        in_pt, in_up, in_pos;
    logic        fr_valid;
    proj_t       fr_proj;

    logic [DIV_STEPS-1:0] dv_vld_reg;
    div_t                 dv_reg [DIV_STEPS], dv_next [DIV_STEPS];
    div_t                 dv_seed, dv_cur;
    logic [RW-1:0]        dv_sh;

    // axis point stages
    logic [1:0]             ax_vld_reg;
    logic signed [2*QW:0]   mul_t [3];
    logic signed [QW:0]     x1_off_reg [3], x1_off_next [3];
    vec_t                   x1_top_reg, x1_bot_reg, x1_pt_reg;
    logic                   x1_in_span_reg, x1_use_top_reg;
    vec_t                   x2_ctr_reg, x2_ctr_next, x2_pt_reg, x2_q;

    logic  sp_valid;
    vec_t  sp_near;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_i_xy_reg  <= ONE_HI;
            base_iz_jx_reg <= '0;
            base_j_yz_reg  <= ONE_HI;
            base_k_xy_reg  <= '0;
            base_kz_cx_reg <= ONE_HI;
            base_c_yz_reg  <= '0;
            rad_half_reg   <= '0;
            rsq_reg        <= '0;
        end
        else
        begin
            // r squared follows the radius register in the next cycle
            rsq_reg <= rsq_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_BASE_I_XY:  base_i_xy_reg  <= cfg_data;
                    CFG_BASE_IZ_JX: base_iz_jx_reg <= cfg_data;
                    CFG_BASE_J_YZ:  base_j_yz_reg  <= cfg_data;
                    CFG_BASE_K_XY:  base_k_xy_reg  <= cfg_data;
                    CFG_BASE_KZ_CX: base_kz_cx_reg <= cfg_data;
                    CFG_BASE_C_YZ:  base_c_yz_reg  <= cfg_data;
                    CFG_RAD_HALF:   rad_half_reg   <= cfg_data;
                    default:        ;  // writes beyond the register list are dropped
                endcase
            end
        end
    end

    // unpack the register halves into rows, x in element 0
    always_comb
    begin
        cfg_w.ri[0] = base_i_xy_reg[63:32];
        cfg_w.ri[1] = base_i_xy_reg[31:0];
        cfg_w.ri[2] = base_iz_jx_reg[63:32];
        cfg_w.rj[0] = base_iz_jx_reg[31:0];
        cfg_w.rj[1] = base_j_yz_reg[63:32];
        cfg_w.rj[2] = base_j_yz_reg[31:0];
        cfg_w.rk[0] = base_k_xy_reg[63:32];
        cfg_w.rk[1] = base_k_xy_reg[31:0];
        cfg_w.rk[2] = base_kz_cx_reg[63:32];
        cfg_w.rc[0] = base_kz_cx_reg[31:0];
        cfg_w.rc[1] = base_c_yz_reg[63:32];
        cfg_w.rc[2] = base_c_yz_reg[31:0];
        cfg_w.r     = rad_half_reg[63:32];
        cfg_w.h     = rad_half_reg[31:0];
        rsq_next    = 64'(cfg_w.r) * 64'(cfg_w.r);
    end

    // stall only when a finished result is held and not taken
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            in_pt[k]  = s_axis_tdata[QW*k +: QW];
            in_up[k]  = s_axis_tdata[QW*(3+k) +: QW];
            in_pos[k] = s_axis_tdata[QW*(6+k) +: QW];
        end
    end

    ccp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_pt     (in_pt),
        .in_up     (in_up),
        .in_pos    (in_pos),
        .cfg       (cfg_w),
        .out_valid (fr_valid),
        .out_proj  (fr_proj)
    );

    // span test and restoring division t = n * 2^32 / d, one quotient bit per stage
    always_comb
    begin
        dv_seed.pt      = fr_proj.pt;
        dv_seed.top     = fr_proj.top;
        dv_seed.bot     = fr_proj.bot;
        dv_seed.hv      = fr_proj.hv;
        dv_seed.in_span = (fr_proj.d > 0) && (fr_proj.n > 0) && (fr_proj.n < fr_proj.d);
        dv_seed.use_top = fr_proj.n <= 0;
        dv_seed.rem     = dv_seed.in_span ? RW'(fr_proj.n[NW-1:0]) : '0;
        dv_seed.den     = RW'(fr_proj.d[NW-1:0]);
        dv_seed.t       = '0;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            dv_cur     = (s == 0) ? dv_seed : dv_reg[(s == 0) ? 0 : s - 1];
            dv_sh      = {dv_cur.rem[RW-2:0], 1'b0};
            dv_next[s] = dv_cur;
            if (dv_sh >= dv_cur.den)
            begin
                dv_next[s].rem = dv_sh - dv_cur.den;
                dv_next[s].t   = {dv_cur.t[TW-2:0], 1'b1};
            end
            else
            begin
                dv_next[s].rem = dv_sh;
                dv_next[s].t   = {dv_cur.t[TW-2:0], 1'b0};
            end
        end

        // axis point q = top + floor(hv * t / 2^32)
        for (int k = 0; k < 3; k++)
        begin
            mul_t[k] = $signed(dv_reg[DIV_STEPS-1].hv[k])
                     * $signed({1'b0, dv_reg[DIV_STEPS-1].t});
            x1_off_next[k] = mul_t[k][2*QW:TW];
            x2_q[k] = sat32(SW'($signed(x1_top_reg[k])) + SW'(x1_off_reg[k]));
        end

        // sphere center: axis point inside the span, else the nearer end
        if (x1_in_span_reg)
            x2_ctr_next = x2_q;
        else if (x1_use_top_reg)
            x2_ctr_next = x1_top_reg;
        else
            x2_ctr_next = x1_bot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg <= '0;
            ax_vld_reg <= '0;
        end
        else if (en)
        begin
            dv_vld_reg <= {dv_vld_reg[DIV_STEPS-2:0], fr_valid};
            ax_vld_reg <= {ax_vld_reg[0], dv_vld_reg[DIV_STEPS-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DIV_STEPS; s++)
                dv_reg[s] <= dv_next[s];
            x1_off_reg     <= x1_off_next;
            x1_top_reg     <= dv_reg[DIV_STEPS-1].top;
            x1_bot_reg     <= dv_reg[DIV_STEPS-1].bot;
            x1_pt_reg      <= dv_reg[DIV_STEPS-1].pt;
            x1_in_span_reg <= dv_reg[DIV_STEPS-1].in_span;
            x1_use_top_reg <= dv_reg[DIV_STEPS-1].use_top;
            x2_ctr_reg     <= x2_ctr_next;
            x2_pt_reg      <= x1_pt_reg;
        end
    end

    ccp_sphere u_sphere (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ax_vld_reg[1]),
        .in_ctr    (x2_ctr_reg),
        .in_pt     (x2_pt_reg),
        .r         (cfg_w.r),
        .rsq       (rsq_reg),
        .out_valid (sp_valid),
        .out_near  (sp_near)
    );

    assign m_axis_tvalid = sp_valid;
    assign m_axis_tdata  = sp_near;

endmodule

// ===== design/ccp_front.sv =====
// front pipeline: frame composition, end centers and projection sums
// depends on ccp_pkg
module ccp_front
    import ccp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  vec_t   in_pt,
    input  vec_t   in_up,
    input  vec_t   in_pos,
    input  cfg_t   cfg,
    output logic   out_valid,
    output proj_t  out_proj
);

    logic [6:0] vld_reg;

    vec_t                   rows [3];
    logic signed [2*QW-1:0] mul_y [3][3];
    logic signed [2*QW-1:0] mul_c [3][3];
    logic signed [2*QW:0]   mul_h [3];
    logic signed [2*QW-1:0] mul_n [3];
    logic signed [2*QW-1:0] mul_d [3];

    // stage a: row products
    logic signed [PW-1:0] a_y_reg [3][3], a_y_next [3][3];
    logic signed [PW-1:0] a_c_reg [3][3], a_c_next [3][3];
    vec_t                 a_pt_reg;
    // stage b: axis and center
    vec_t b_ax_reg, b_ax_next, b_ce_reg, b_ce_next, b_pt_reg;
    // stage c: half length offset
    logic signed [OW-1:0] c_off_reg [3], c_off_next [3];
    vec_t                 c_ce_reg, c_pt_reg;
    // stage d: end centers
    vec_t d_top_reg, d_top_next, d_bot_reg, d_bot_next, d_pt_reg;
    // stage e: segment and point offset
    vec_t e_hv_reg, e_hv_next, e_dv_reg, e_dv_next, e_top_reg, e_bot_reg, e_pt_reg;
    // stage f: dot product terms
    logic signed [PW-1:0] f_n_reg [3], f_n_next [3], f_d_reg [3], f_d_next [3];
    vec_t                 f_hv_reg, f_top_reg, f_bot_reg, f_pt_reg;
    // stage g: sums
    proj_t g_reg, g_next;

    always_comb
    begin
        rows[0] = cfg.ri;
        rows[1] = cfg.rj;
        rows[2] = cfg.rk;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                mul_y[k][j]    = $signed(in_up[j]) * $signed(rows[j][k]);
                mul_c[k][j]    = $signed(in_pos[j]) * $signed(rows[j][k]);
                a_y_next[k][j] = mul_y[k][j][2*QW-1:FRAC_BITS];
                a_c_next[k][j] = mul_c[k][j][2*QW-1:FRAC_BITS];
            end
            b_ax_next[k] = sat32(SW'(a_y_reg[k][0]) + SW'(a_y_reg[k][1])
                               + SW'(a_y_reg[k][2]));
            b_ce_next[k] = sat32(SW'(a_c_reg[k][0]) + SW'(a_c_reg[k][1])
                               + SW'(a_c_reg[k][2]) + SW'($signed(cfg.rc[k])));
            mul_h[k]      = $signed({1'b0, cfg.h}) * $signed(b_ax_reg[k]);
            c_off_next[k] = mul_h[k][2*QW:FRAC_BITS];
            d_top_next[k] = sat32(SW'($signed(c_ce_reg[k])) + SW'(c_off_reg[k]));
            d_bot_next[k] = sat32(SW'($signed(c_ce_reg[k])) - SW'(c_off_reg[k]));
            e_hv_next[k]  = sat32(SW'($signed(d_bot_reg[k])) - SW'($signed(d_top_reg[k])));
            e_dv_next[k]  = sat32(SW'($signed(d_pt_reg[k])) - SW'($signed(d_top_reg[k])));
            mul_n[k]      = $signed(e_dv_reg[k]) * $signed(e_hv_reg[k]);
            mul_d[k]      = $signed(e_hv_reg[k]) * $signed(e_hv_reg[k]);
            f_n_next[k]   = mul_n[k][2*QW-1:FRAC_BITS];
            f_d_next[k]   = mul_d[k][2*QW-1:FRAC_BITS];
        end
        g_next.pt  = f_pt_reg;
        g_next.top = f_top_reg;
        g_next.bot = f_bot_reg;
        g_next.hv  = f_hv_reg;
        g_next.n   = NW'(f_n_reg[0]) + NW'(f_n_reg[1]) + NW'(f_n_reg[2]);
        g_next.d   = NW'(f_d_reg[0]) + NW'(f_d_reg[1]) + NW'(f_d_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[5:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_y_reg   <= a_y_next;
            a_c_reg   <= a_c_next;
            a_pt_reg  <= in_pt;
            b_ax_reg  <= b_ax_next;
            b_ce_reg  <= b_ce_next;
            b_pt_reg  <= a_pt_reg;
            c_off_reg <= c_off_next;
            c_ce_reg  <= b_ce_reg;
            c_pt_reg  <= b_pt_reg;
            d_top_reg <= d_top_next;
            d_bot_reg <= d_bot_next;
            d_pt_reg  <= c_pt_reg;
            e_hv_reg  <= e_hv_next;
            e_dv_reg  <= e_dv_next;
            e_top_reg <= d_top_reg;
            e_bot_reg <= d_bot_reg;
            e_pt_reg  <= d_pt_reg;
            f_n_reg   <= f_n_next;
            f_d_reg   <= f_d_next;
            f_hv_reg  <= e_hv_reg;
            f_top_reg <= e_top_reg;
            f_bot_reg <= e_bot_reg;
            f_pt_reg  <= e_pt_reg;
            g_reg     <= g_next;
        end
    end

    assign out_valid = vld_reg[6];
    assign out_proj  = g_reg;

endmodule

// ===== design/ccp_sphere.sv =====
// sphere stage: distance, pipelined square root and per-axis push division
// depends on ccp_pkg
module ccp_sphere
    import ccp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  vec_t           in_ctr,
    input  vec_t           in_pt,
    input  logic [QW-1:0]  r,
    input  logic [63:0]    rsq,
    output logic           out_valid,
    output vec_t           out_near
);

    typedef struct packed {
        logic [63:0]            x;
        logic [63:0]            res;
        logic [2:0][2*QW-1:0]   mr;
        logic [2:0]             neg;
        vec_t                   ctr;
        vec_t                   pt;
        logic                   in_ball;
        logic                   zero;
    } sq_t;

    typedef struct packed {
        logic [2:0][QW-1:0] rem;
        logic [2:0][QW-1:0] low;
        logic [2:0][QW-1:0] q;
        logic [QW-1:0]      len;
        logic [2:0]         neg;
        vec_t               ctr;
        vec_t               pt;
        logic               in_ball;
        logic               zero;
    } pd_t;

    logic [2:0]            pre_vld_reg;
    logic [SQ_STEPS-1:0]   sq_vld_reg;
    logic [PD_STEPS-1:0]   pd_vld_reg;
    logic                  out_vld_reg;

    // distance stages
    vec_t                  j_m_reg, j_m_next, j_v;
    logic [2:0]            j_neg_reg, j_neg_next;
    vec_t                  j_ctr_reg, j_pt_reg;
    logic [2:0][2*QW-1:0]  k_mm_reg, k_mm_next, k_mr_reg, k_mr_next;
    logic [2:0]            k_neg_reg;
    vec_t                  k_ctr_reg, k_pt_reg;
    logic [63:0]           l_ss_reg, l_ss_next;
    logic [2:0][2*QW-1:0]  l_mr_reg;
    logic [2:0]            l_neg_reg;
    vec_t                  l_ctr_reg, l_pt_reg;

    sq_t  sq_reg [SQ_STEPS], sq_next [SQ_STEPS];
    sq_t  sq_seed, sq_cur;
    logic [63:0] sq_bit, sq_trial;

    pd_t  pd_reg [PD_STEPS], pd_next [PD_STEPS];
    pd_t  pd_seed, pd_cur;
    logic [QW:0] pd_sh;

    vec_t out_reg, out_next;
    logic signed [SW-1:0] ofs;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            j_v[k]        = sat32(SW'($signed(in_pt[k])) - SW'($signed(in_ctr[k])));
            j_neg_next[k] = j_v[k][QW-1];
            j_m_next[k]   = j_v[k][QW-1] ? (~j_v[k] + 1'b1) : j_v[k];
            k_mm_next[k]  = 64'(j_m_reg[k]) * 64'(j_m_reg[k]);
            k_mr_next[k]  = 64'(j_m_reg[k]) * 64'(r);
        end
        l_ss_next = k_mm_reg[0] + k_mm_reg[1] + k_mm_reg[2];

        // square root, one result bit per stage
        sq_seed.x       = l_ss_reg;
        sq_seed.res     = '0;
        sq_seed.mr      = l_mr_reg;
        sq_seed.neg     = l_neg_reg;
        sq_seed.ctr     = l_ctr_reg;
        sq_seed.pt      = l_pt_reg;
        sq_seed.in_ball = l_ss_reg < rsq;
        sq_seed.zero    = l_ss_reg == '0;
        for (int s = 0; s < SQ_STEPS; s++)
        begin
            sq_cur   = (s == 0) ? sq_seed : sq_reg[(s == 0) ? 0 : s - 1];
            sq_bit   = 64'(1) << (2 * (SQ_STEPS - 1 - s));
            sq_trial = sq_cur.res + sq_bit;
            sq_next[s] = sq_cur;
            if (sq_cur.x >= sq_trial)
            begin
                sq_next[s].x   = sq_cur.x - sq_trial;
                sq_next[s].res = (sq_cur.res >> 1) + sq_bit;
            end
            else
            begin
                sq_next[s].res = sq_cur.res >> 1;
            end
        end

        // push division, quotient never exceeds r so upper bits seed the remainder
        pd_seed.len     = sq_reg[SQ_STEPS-1].res[QW-1:0];
        pd_seed.neg     = sq_reg[SQ_STEPS-1].neg;
        pd_seed.ctr     = sq_reg[SQ_STEPS-1].ctr;
        pd_seed.pt      = sq_reg[SQ_STEPS-1].pt;
        pd_seed.in_ball = sq_reg[SQ_STEPS-1].in_ball;
        pd_seed.zero    = sq_reg[SQ_STEPS-1].zero;
        for (int k = 0; k < 3; k++)
        begin
            pd_seed.rem[k] = {1'b0, sq_reg[SQ_STEPS-1].mr[k][2*QW-2:QW]};
            pd_seed.low[k] = sq_reg[SQ_STEPS-1].mr[k][QW-1:0];
            pd_seed.q[k]   = '0;
        end
        for (int s = 0; s < PD_STEPS; s++)
        begin
            pd_cur     = (s == 0) ? pd_seed : pd_reg[(s == 0) ? 0 : s - 1];
            pd_next[s] = pd_cur;
            for (int k = 0; k < 3; k++)
            begin
                pd_sh = {pd_cur.rem[k], pd_cur.low[k][QW-1]};
                pd_next[s].low[k] = {pd_cur.low[k][QW-2:0], 1'b0};
                if (pd_sh >= {1'b0, pd_cur.len})
                begin
                    pd_next[s].rem[k] = QW'(pd_sh - {1'b0, pd_cur.len});
                    pd_next[s].q[k]   = {pd_cur.q[k][QW-2:0], 1'b1};
                end
                else
                begin
                    pd_next[s].rem[k] = pd_sh[QW-1:0];
                    pd_next[s].q[k]   = {pd_cur.q[k][QW-2:0], 1'b0};
                end
            end
        end

        for (int k = 0; k < 3; k++)
        begin
            ofs = SW'($signed({1'b0, pd_reg[PD_STEPS-1].q[k]}));
            if (pd_reg[PD_STEPS-1].in_ball)
                out_next[k] = pd_reg[PD_STEPS-1].pt[k];
            else if (pd_reg[PD_STEPS-1].zero)
                out_next[k] = pd_reg[PD_STEPS-1].ctr[k];
            else if (pd_reg[PD_STEPS-1].neg[k])
                out_next[k] = sat32(SW'($signed(pd_reg[PD_STEPS-1].ctr[k])) - ofs);
            else
                out_next[k] = sat32(SW'($signed(pd_reg[PD_STEPS-1].ctr[k])) + ofs);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg <= '0;
            sq_vld_reg  <= '0;
            pd_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            pre_vld_reg <= {pre_vld_reg[1:0], in_valid};
            sq_vld_reg  <= {sq_vld_reg[SQ_STEPS-2:0], pre_vld_reg[2]};
            pd_vld_reg  <= {pd_vld_reg[PD_STEPS-2:0], sq_vld_reg[SQ_STEPS-1]};
            out_vld_reg <= pd_vld_reg[PD_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            j_m_reg   <= j_m_next;
            j_neg_reg <= j_neg_next;
            j_ctr_reg <= in_ctr;
            j_pt_reg  <= in_pt;
            k_mm_reg  <= k_mm_next;
            k_mr_reg  <= k_mr_next;
            k_neg_reg <= j_neg_reg;
            k_ctr_reg <= j_ctr_reg;
            k_pt_reg  <= j_pt_reg;
            l_ss_reg  <= l_ss_next;
            l_mr_reg  <= k_mr_reg;
            l_neg_reg <= k_neg_reg;
            l_ctr_reg <= k_ctr_reg;
            l_pt_reg  <= k_pt_reg;
            for (int s = 0; s < SQ_STEPS; s++)
                sq_reg[s] <= sq_next[s];
            for (int s = 0; s < PD_STEPS; s++)
                pd_reg[s] <= pd_next[s];
            out_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_near  = out_reg;

endmodule

// ===== design/ccp_checker.sv =====
// port-level checks for the capsule closest point block, bound to the top level
// depends on capsule_closest_point_top_macros.svh
`include "capsule_closest_point_top_macros.svh"

module ccp_checker (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic cfg_ready
);

    // a held result stays offered
    `CCP_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    // a stalled output blocks new transactions
    `CCP_ASSERT_IMP(a_in_stall, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    // a free output always lets a transaction in, and configuration is always taken
    `CCP_ASSERT_IMP(a_in_free, !m_axis_tvalid || m_axis_tready, s_axis_tready && cfg_ready)
    // nothing offered during reset
    `CCP_ASSERT_ALL(a_rst_quiet, rst_n || !m_axis_tvalid)

endmodule

bind capsule_closest_point_top ccp_checker u_ccp_checker (.*);
